@@ hw/rtl/ecg_pkg.sv @@
// ----------------------------------------------------------------------------
// ecg_pkg
// shared constants, types and tables for the energy column to gray converter
// ----------------------------------------------------------------------------
package ecg_pkg;

  localparam int MAX_ROWS_DEF     = 1024;
  localparam int MAX_COLUMNS_DEF  = 4096;
  localparam int MAX_ENERGIES_DEF = 8;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 19;
  localparam int GRAY_W   = 8;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_WIDTH_W = 13;
  localparam int CFG_HEIGHT_W = 11;
  localparam int CFG_ECNT_W  = 4;
  localparam int CFG_MODE_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_COLUMNS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ROWS    = 3'd5;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 13'd4096;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 11'd1024;
  localparam logic [CFG_ECNT_W-1:0]   ECNT_RST   = 4'd2;
  localparam logic [CFG_MODE_W-1:0]   MODE_RST   = 2'd2;

  localparam logic [CFG_MODE_W-1:0] MODE_FIRST  = 2'd0;
  localparam logic [CFG_MODE_W-1:0] MODE_SECOND = 2'd1;

  // reciprocal scaling: floor(x/e) == (x * ceil(2^24/e)) >> 24 for x < 2^19, e < 16
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] e2;
    logic [SAMPLE_W-1:0] e1;
  } ecg_entry_t;

  localparam int ENTRY_W = $bits(ecg_entry_t);

  function automatic logic [RECIP_W-1:0] ecg_recip(input logic [CFG_ECNT_W-1:0] e);
    logic [RECIP_W-1:0] m;
    case (e)
      4'd2:    m = 25'd8388608;
      4'd3:    m = 25'd5592406;
      4'd4:    m = 25'd4194304;
      4'd5:    m = 25'd3355444;
      4'd6:    m = 25'd2796203;
      4'd7:    m = 25'd2396746;
      4'd8:    m = 25'd2097152;
      4'd9:    m = 25'd1864136;
      4'd10:   m = 25'd1677722;
      4'd11:   m = 25'd1525202;
      4'd12:   m = 25'd1398102;
      4'd13:   m = 25'd1290556;
      4'd14:   m = 25'd1198373;
      4'd15:   m = 25'd1118482;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/energy_column_to_gray_pixels.sv @@
// ----------------------------------------------------------------------------
// energy_column_to_gray_pixels
// per-row energy store and gray pixel emission with optional mirroring
// ----------------------------------------------------------------------------
// path: a sample passes stage 1, stage 2 and the output register before its pixel is on out_
// throughput: one sample per cycle unless out_ready stalls a pixel; per-row state is read, updated and
//   written back through one ram, back-to-back hits on a row are forwarded
// reset: position counters and pipeline cleared, registers to defaults,
//   row store left undefined and not cleared
module energy_column_to_gray_pixels #(
  parameter int MAX_ROWS     = ecg_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS  = ecg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ENERGIES = ecg_pkg::MAX_ENERGIES_DEF,
  parameter int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ecg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ecg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ecg_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ecg_pkg::GRAY_W-1:0]      out_gray_value,
  output logic [ROW_W-1:0]                out_dest_row,
  output logic [COL_W-1:0]                out_dest_col,
  output logic                            out_frame_last
);

  import ecg_pkg::*;

  localparam int ENG_W = (MAX_ENERGIES > 1) ? $clog2(MAX_ENERGIES) : 1;

  // configuration
  logic [CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [CFG_HEIGHT_W-1:0] cfg_height_r;
  logic [CFG_ECNT_W-1:0]   cfg_ecnt_r;
  logic [CFG_MODE_W-1:0]   cfg_mode_r;
  logic                    cfg_mcol_r;
  logic                    cfg_mrow_r;

  logic [COL_W-1:0]      w_m1;
  logic [ROW_W-1:0]      h_m1;
  logic [CFG_ECNT_W-1:0] e_c;
  logic [ENG_W-1:0]      e_m1;

  // position
  logic [ROW_W-1:0] row_r;
  logic [ENG_W-1:0] energy_r;
  logic [COL_W-1:0] col_r;

  // stage 1: ram read data
  logic                    s1_v_r;
  logic [SAMPLE_W-1:0]     s1_sample_r;
  logic [ROW_W-1:0]        s1_row_r;
  logic                    s1_first_r;
  logic                    s1_second_r;
  logic                    s1_emit_r;
  logic                    s1_multi_r;
  logic [CFG_MODE_W-1:0]   s1_mode_r;
  logic [CFG_ECNT_W-1:0]   s1_ecnt_r;
  logic [ROW_W-1:0]        s1_drow_r;
  logic [COL_W-1:0]        s1_dcol_r;
  logic                    s1_last_r;
  logic                    fwd_r;
  ecg_entry_t              fwd_data_r;

  // stage 2: multiplier operands
  logic                    s2_v_r;
  logic [SUM_W-1:0]        s2_sum_r;
  logic [RECIP_W-1:0]      s2_recip_r;
  logic                    s2_avg_r;
  logic [GRAY_W-1:0]       s2_direct_r;
  logic [ROW_W-1:0]        s2_drow_r;
  logic [COL_W-1:0]        s2_dcol_r;
  logic                    s2_last_r;

  // output register
  logic                    out_valid_r;
  logic [GRAY_W-1:0]       out_gray_r;
  logic [ROW_W-1:0]        out_drow_r;
  logic [COL_W-1:0]        out_dcol_r;
  logic                    out_last_r;

  logic        in_acc;
  logic        s1_leave;
  logic        s2_leave;
  logic        out_room;
  ecg_entry_t  ram_rdata;
  ecg_entry_t  cur;
  ecg_entry_t  upd;
  logic [SAMPLE_W-1:0] e2_sel;
  logic [GRAY_W-1:0]   direct_gray;
  logic [PROD_W-1:0]   prod;
  logic [ROW_W-1:0]    drow;
  logic [COL_W-1:0]    dcol;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
      cfg_ecnt_r   <= ECNT_RST;
      cfg_mode_r   <= MODE_RST;
      cfg_mcol_r   <= 1'b0;
      cfg_mrow_r   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    cfg_width_r  <= cfg_data[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:   cfg_height_r <= cfg_data[CFG_HEIGHT_W-1:0];
        CFG_ENERGY_COUNT:   cfg_ecnt_r   <= cfg_data[CFG_ECNT_W-1:0];
        CFG_ENERGY_MODE:    cfg_mode_r   <= cfg_data[CFG_MODE_W-1:0];
        CFG_MIRROR_COLUMNS: cfg_mcol_r   <= cfg_data[0];
        CFG_MIRROR_ROWS:    cfg_mrow_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped last positions
  always_comb begin
    if (cfg_width_r == '0) begin
      w_m1 = '0;
    end else if (32'(cfg_width_r) > 32'(MAX_COLUMNS)) begin
      w_m1 = COL_W'(MAX_COLUMNS - 1);
    end else begin
      w_m1 = COL_W'(32'(cfg_width_r) - 32'd1);
    end
    if (cfg_height_r == '0) begin
      h_m1 = '0;
    end else if (32'(cfg_height_r) > 32'(MAX_ROWS)) begin
      h_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      h_m1 = ROW_W'(32'(cfg_height_r) - 32'd1);
    end
    if (cfg_ecnt_r == '0) begin
      e_c = CFG_ECNT_W'(1);
    end else if (32'(cfg_ecnt_r) > 32'(MAX_ENERGIES)) begin
      e_c = CFG_ECNT_W'(MAX_ENERGIES);
    end else begin
      e_c = cfg_ecnt_r;
    end
    e_m1 = ENG_W'(32'(e_c) - 32'd1);
  end

  assign drow = cfg_mrow_r ? ROW_W'(h_m1 - row_r) : row_r;
  assign dcol = cfg_mcol_r ? COL_W'(w_m1 - col_r) : col_r;

  // pipeline flow
  assign out_room = !out_valid_r || out_ready;
  assign s2_leave = s2_v_r && out_room;
  assign s1_leave = s1_v_r && (!s1_emit_r || !s2_v_r || s2_leave);
  assign in_ready = !s1_v_r || s1_leave;
  assign in_acc   = in_valid && in_ready;

  ecg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ROWS),
    .AW    (ROW_W)
  ) u_store (
    .clk   (clk),
    .we    (s1_leave),
    .waddr (s1_row_r),
    .wdata (upd),
    .re    (in_acc),
    .raddr (row_r),
    .rdata (ram_rdata)
  );

  // read-modify-write of the row entry
  always_comb begin
    cur     = fwd_r ? fwd_data_r : ram_rdata;
    upd.e1  = s1_first_r ? s1_sample_r : cur.e1;
    upd.e2  = s1_second_r ? s1_sample_r : cur.e2;
    upd.sum = s1_first_r ? SUM_W'(s1_sample_r) : SUM_W'(cur.sum + SUM_W'(s1_sample_r));
    e2_sel  = s1_multi_r ? upd.e2 : upd.e1;
    if (s1_mode_r == MODE_FIRST) begin
      direct_gray = upd.e1[SAMPLE_W-1 -: GRAY_W];
    end else begin
      direct_gray = e2_sel[SAMPLE_W-1 -: GRAY_W];
    end
  end

  assign prod = PROD_W'(s2_sum_r) * PROD_W'(s2_recip_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      energy_r    <= '0;
      col_r       <= '0;
      s1_v_r      <= 1'b0;
      fwd_r       <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (row_r >= h_m1) begin
          row_r <= '0;
          if (energy_r >= e_m1) begin
            energy_r <= '0;
            if (col_r >= w_m1) begin
              col_r <= '0;
            end else begin
              col_r <= col_r + 1'b1;
            end
          end else begin
            energy_r <= energy_r + 1'b1;
          end
        end else begin
          row_r <= row_r + 1'b1;
        end
      end

      if (in_acc) begin
        s1_v_r <= 1'b1;
        fwd_r  <= s1_leave && (s1_row_r == row_r);
      end else if (s1_leave) begin
        s1_v_r <= 1'b0;
        fwd_r  <= 1'b0;
      end

      if (s1_leave && s1_emit_r) begin
        s2_v_r <= 1'b1;
      end else if (s2_leave) begin
        s2_v_r <= 1'b0;
      end

      if (s2_leave) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample;
      s1_row_r    <= row_r;
      s1_first_r  <= (energy_r == '0);
      s1_second_r <= (energy_r == ENG_W'(1));
      s1_emit_r   <= (energy_r >= e_m1);
      s1_multi_r  <= (e_c >= CFG_ECNT_W'(2));
      s1_mode_r   <= cfg_mode_r;
      s1_ecnt_r   <= e_c;
      s1_drow_r   <= drow;
      s1_dcol_r   <= dcol;
      s1_last_r   <= (col_r >= w_m1) && (row_r >= h_m1);
    end
    if (s1_leave) begin
      fwd_data_r <= upd;
    end
    if (s1_leave && s1_emit_r) begin
      s2_sum_r    <= upd.sum;
      s2_recip_r  <= ecg_recip(s1_ecnt_r);
      s2_avg_r    <= (s1_mode_r != MODE_FIRST) && (s1_mode_r != MODE_SECOND);
      s2_direct_r <= direct_gray;
      s2_drow_r   <= s1_drow_r;
      s2_dcol_r   <= s1_dcol_r;
      s2_last_r   <= s1_last_r;
    end
    if (s2_leave) begin
      out_gray_r <= s2_avg_r ? prod[RECIP_SHIFT+SAMPLE_W-1 -: GRAY_W] : s2_direct_r;
      out_drow_r <= s2_drow_r;
      out_dcol_r <= s2_dcol_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gray_value = out_gray_r;
  assign out_dest_row   = out_drow_r;
  assign out_dest_col   = out_dcol_r;
  assign out_frame_last = out_last_r;

  // checks
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r)
    else $error("forward flag set with no item in stage 1");

  a_s2_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_leave && s1_emit_r) |-> (!s2_v_r || s2_leave))
    else $error("stage 2 overwritten before transfer");

  a_energy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    energy_r <= ENG_W'(MAX_ENERGIES - 1))
    else $error("energy counter out of range");

endmodule

@@ hw/rtl/ecg_ram.sv @@
// ----------------------------------------------------------------------------
// ecg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ecg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ tb/ecg_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// ecg_pixel_checker
// follows register writes and sample transfers, works out the gray pixel that
// each row's last energy sample should produce and compares every pixel
// transfer against the oldest pixel still due
// ----------------------------------------------------------------------------
module ecg_pixel_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ecg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [ecg_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ecg_pkg::GRAY_W-1:0]     out_gray_value,
  input  logic [9:0]                     out_dest_row,
  input  logic [11:0]                    out_dest_col,
  input  logic                           out_frame_last,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ecg_pkg::*;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [9:0]        row;
    logic [11:0]       col;
    logic              last;
  } pixel_t;

  logic [CFG_WIDTH_W-1:0]  width_q;
  logic [CFG_HEIGHT_W-1:0] height_q;
  logic [CFG_ECNT_W-1:0]   ecount_q;
  logic [CFG_MODE_W-1:0]   mode_q;
  logic                    mirror_col_q;
  logic                    mirror_row_q;

  int unsigned col_pos;
  int unsigned energy_pos;
  int unsigned row_pos;

  logic [SAMPLE_W-1:0] first_mem  [MAX_ROWS_DEF];
  logic [SAMPLE_W-1:0] second_mem [MAX_ROWS_DEF];
  logic [SUM_W-1:0]    sum_mem    [MAX_ROWS_DEF];

  pixel_t pixels_due[$];
  int     mismatches = 0;

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] pixel mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : track_pixels
    int unsigned w;
    int unsigned h;
    int unsigned e;
    int unsigned v;
    int unsigned dr;
    int unsigned dc;
    pixel_t px;
    pixel_t got;
    if (!rst_n) begin
      width_q      = WIDTH_RST;
      height_q     = HEIGHT_RST;
      ecount_q     = ECNT_RST;
      mode_q       = MODE_RST;
      mirror_col_q = 1'b0;
      mirror_row_q = 1'b1;
      col_pos      = 0;
      energy_pos   = 0;
      row_pos      = 0;
      pixels_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:    width_q      = cfg_data[CFG_WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT:   height_q     = cfg_data[CFG_HEIGHT_W-1:0];
          CFG_ENERGY_COUNT:   ecount_q     = cfg_data[CFG_ECNT_W-1:0];
          CFG_ENERGY_MODE:    mode_q       = cfg_data[CFG_MODE_W-1:0];
          CFG_MIRROR_COLUMNS: mirror_col_q = cfg_data[0];
          CFG_MIRROR_ROWS:    mirror_row_q = cfg_data[0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        w = clamp_count(width_q, MAX_COLUMNS_DEF);
        h = clamp_count(height_q, MAX_ROWS_DEF);
        e = clamp_count(ecount_q, MAX_ENERGIES_DEF);
        if (energy_pos == 0) begin
          first_mem[row_pos] = in_sample;
          sum_mem[row_pos]   = SUM_W'(in_sample);
        end else begin
          if (energy_pos == 1) second_mem[row_pos] = in_sample;
          sum_mem[row_pos] = sum_mem[row_pos] + SUM_W'(in_sample);
        end

        if (energy_pos >= e - 1) begin
          case (mode_q)
            MODE_FIRST:  v = first_mem[row_pos];
            MODE_SECOND: v = (e >= 2) ? second_mem[row_pos] : first_mem[row_pos];
            default:     v = sum_mem[row_pos] / e;
          endcase
          dr = mirror_row_q ? (h - 1 - row_pos) : row_pos;
          dc = mirror_col_q ? (w - 1 - col_pos) : col_pos;
          px.gray = v[15:8];
          px.row  = dr[9:0];
          px.col  = dc[11:0];
          px.last = (col_pos >= w - 1) && (row_pos >= h - 1);
          pixels_due.push_back(px);
        end

        if (row_pos >= h - 1) begin
          row_pos = 0;
          if (energy_pos >= e - 1) begin
            energy_pos = 0;
            col_pos = (col_pos >= w - 1) ? 0 : col_pos + 1;
          end else begin
            energy_pos++;
          end
        end else begin
          row_pos++;
        end
      end

      if (out_valid && out_ready) begin
        got = '{out_gray_value, out_dest_row, out_dest_col, out_frame_last};
        if (pixels_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected pixel gray %0d row %0d col %0d last %0b",
                                  got.gray, got.row, got.col, got.last));
        end else begin
          px = pixels_due.pop_front();
          if (got.gray != px.gray || got.row != px.row || got.col != px.col ||
              got.last != px.last) begin
            flag_mismatch($sformatf(
              "gray %0d/%0d row %0d/%0d col %0d/%0d last %0b/%0b (got/exp)",
              got.gray, px.gray, got.row, px.row, got.col, px.col, got.last, px.last));
          end
        end
      end
    end
    pending    <= pixels_due.size();
    fail_count <= mismatches;
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random sample streams through the energy column to
// gray converter under several register settings and idling profiles;
// the pixel checker predicts and compares every pixel transfer
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ecg_pkg::*;

  localparam logic [CFG_MODE_W-1:0] MODE_AVERAGE = 2'd2;
  localparam logic [CFG_MODE_W-1:0] MODE_SPARE   = 2'd3;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_ready = 1'b0;

  logic                  cfg_ready;
  logic                  in_ready;
  logic                  out_valid;
  logic [GRAY_W-1:0]     out_gray_value;
  logic [9:0]            out_dest_row;
  logic [11:0]           out_dest_col;
  logic                  out_frame_last;

  int          fail_count;
  int          pending;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  always #1 clk = ~clk;

  energy_column_to_gray_pixels dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_gray_value (out_gray_value),
    .out_dest_row   (out_dest_row),
    .out_dest_col   (out_dest_col),
    .out_frame_last (out_frame_last)
  );

  ecg_pixel_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_gray_value (out_gray_value),
    .out_dest_row   (out_dest_row),
    .out_dest_col   (out_dest_col),
    .out_frame_last (out_frame_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always @(posedge clk) begin
    if (stall_pct == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic apply_settings(input logic [12:0] w, input logic [10:0] h,
                                input logic [3:0] e, input logic [1:0] m,
                                input logic mc, input logic mr);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_ENERGY_COUNT,
            CFG_ENERGY_MODE, CFG_MIRROR_COLUMNS, CFG_MIRROR_ROWS};
    val = '{w, 13'(h), 13'(e), 13'(m), 13'(mc), 13'(mr)};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drain every pixel due, then let the pipeline run empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [12:0]   w;
    logic [10:0]   h;
    logic [3:0]    e;
    logic [1:0]    m;
    logic          mc;
    logic          mr;
    logic [15:0]   s;
    int unsigned   hc;
    int unsigned   ec;
    int unsigned   cols;
    int unsigned   items;
    int            phase;
    int            random_sent;
    bit            big;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // mirrored 2x2 frame, first energy, sample extremes
    apply_settings(13'd2, 11'd2, 4'd1, MODE_FIRST, 1'b1, 1'b1);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    settle();

    // single column frame, second energy
    apply_settings(13'd1, 11'd3, 4'd2, MODE_SECOND, 1'b0, 1'b0);
    push_sample(16'h00FF);
    push_sample(16'hFF00);
    push_sample(16'h5555);
    push_sample(16'hAAAA);
    push_sample(16'h1234);
    push_sample(16'hFEDC);
    settle();

    // full sum over eight energies
    apply_settings(13'd1, 11'd1, 4'd8, MODE_AVERAGE, 1'b0, 1'b1);
    repeat (8) push_sample(16'hFFFF);
    settle();

    // single energy: second energy falls back to the first
    apply_settings(13'd3, 11'd2, 4'd1, MODE_SECOND, 1'b1, 1'b0);
    push_sample(16'h0100);
    push_sample(16'hABCD);
    settle();

    // spare mode code behaves as the average
    apply_settings(13'd1, 11'd1, 4'd3, MODE_SPARE, 1'b0, 1'b0);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    push_sample(16'h8001);
    settle();

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 82; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 82; end
        default: begin idle_pct = 28; stall_pct <= 28; end
      endcase

      big = 1'b0;
      if (phase == 1) begin
        big = 1'b1;
        w = 13'd8191; h = 11'd2047; e = 4'd0; m = MODE_AVERAGE; mc = 1'b1; mr = 1'b1;
      end else begin
        case ($urandom_range(9))
          0:       w = 13'd0;
          1:       w = 13'd4096;
          default: w = 13'($urandom_range(1, 6));
        endcase
        h = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
        case ($urandom_range(9))
          0:       e = 4'd0;
          1:       e = 4'd15;
          default: e = 4'($urandom_range(1, 8));
        endcase
        m  = 2'($urandom_range(3));
        mc = 1'($urandom_range(1));
        mr = 1'($urandom_range(1));
      end

      hc = (h == 0) ? 1 : ((h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : h);
      ec = (e == 0) ? 1 : ((e > MAX_ENERGIES_DEF) ? MAX_ENERGIES_DEF : e);
      cols = big ? 1 : 1 + $urandom_range(0, 160 / (hc * ec));
      items = cols * hc * ec;

      apply_settings(w, h, e, m, mc, mr);
      for (int unsigned i = 0; i < items; i++) begin
        case ($urandom_range(7))
          0:       s = 16'hFFFF;
          1:       s = 16'h0000;
          default: s = 16'($urandom);
        endcase
        push_sample(s);
      end
      settle();

      random_sent += items;
      phase++;
    end

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ecg_pkg.sv
hw/rtl/ecg_ram.sv
hw/rtl/energy_column_to_gray_pixels.sv
tb/ecg_pixel_checker.sv
tb/tb_top.sv
